>>> hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    // Field widths fixed by the item format.
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int OFF_W   = 24;
    localparam int CNT_W   = 9;
    localparam int BYTES_W = 16;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Default pool depth.
    localparam int MAX_BLOCKS_DEF = 256;

    // Register reset values.
    localparam logic [CNT_W-1:0]   BLOCK_COUNT_RST = 9'd256;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd16;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;

    // Function codes.
    localparam t_func FUNC_ALLOC = 2'd0;
    localparam t_func FUNC_FREE  = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;

    // Status codes.
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_BADOFF = 2'd3;

    // Register indexes, selected by paddr[2].
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_BYTES = 1'b1;

endpackage

>>> hw/rtl/fbpa_if.sv
// Request channel: one allocator command per beat.
interface fbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbpa_pkg::FUNC_W-1:0]   func;
    logic [fbpa_pkg::OFF_W-1:0]    free_offset;

    modport source (output valid, func, free_offset, input ready);
    modport sink   (input valid, func, free_offset, output ready);
endinterface

// Response channel: one result per beat.
interface fbpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbpa_pkg::STAT_W-1:0]   status;
    logic [fbpa_pkg::OFF_W-1:0]    block_offset;
    logic [fbpa_pkg::CNT_W-1:0]    available;
    logic [fbpa_pkg::CNT_W-1:0]    allocated;

    modport source (output valid, status, block_offset, available, allocated, input ready);
    modport sink   (input valid, status, block_offset, available, allocated, output ready);
endinterface

>>> hw/rtl/fbpa_cfg.sv
module fbpa_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbpa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fbpa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fbpa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [fbpa_pkg::CNT_W-1:0]          o_block_count,
    output logic [fbpa_pkg::BYTES_W-1:0]        o_block_bytes
);

    logic [fbpa_pkg::CNT_W-1:0]   r_block_count;
    logic [fbpa_pkg::BYTES_W-1:0] r_block_bytes;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= fbpa_pkg::BLOCK_COUNT_RST;
            r_block_bytes <= fbpa_pkg::BLOCK_BYTES_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                fbpa_pkg::REG_BLOCK_COUNT: r_block_count <= pwdata[fbpa_pkg::CNT_W-1:0];
                fbpa_pkg::REG_BLOCK_BYTES: r_block_bytes <= pwdata[fbpa_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (paddr[2])
            fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::APB_DATA_W'(r_block_count);
            fbpa_pkg::REG_BLOCK_BYTES: prdata = fbpa_pkg::APB_DATA_W'(r_block_bytes);
            default:                   prdata = '0;
        endcase
    end

    assign o_block_count = r_block_count;
    assign o_block_bytes = r_block_bytes;

endmodule

>>> hw/rtl/fbpa_div.sv
module fbpa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fbpa_pkg::OFF_W-1:0]        i_dividend,
    input  logic [fbpa_pkg::BYTES_W-1:0]      i_divisor,
    output logic                              o_done,
    output logic [fbpa_pkg::OFF_W-1:0]        o_quot
);

    localparam int STEP_W = $clog2(fbpa_pkg::OFF_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fbpa_pkg::OFF_W - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [STEP_W-1:0]              r_step;
    logic [fbpa_pkg::OFF_W-1:0]     r_dvd;
    logic [fbpa_pkg::BYTES_W-1:0]   r_rem;
    logic [fbpa_pkg::BYTES_W-1:0]   r_dsr;
    logic [fbpa_pkg::BYTES_W:0]     w_trial;
    logic                           w_ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign w_trial = {r_rem, r_dvd[fbpa_pkg::OFF_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: the dividend register collects quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[fbpa_pkg::OFF_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= fbpa_pkg::BYTES_W'(w_trial - {1'b0, r_dsr});
            end else begin
                r_rem <= w_trial[fbpa_pkg::BYTES_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

>>> hw/rtl/fbpa_stack.sv
module fbpa_stack #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_rd_addr,
    output logic [$clog2(MAX_BLOCKS)-1:0]     o_rd_data,
    input  logic                              i_wr_en,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_wr_addr,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     i_wr_data
);

    localparam int AW = $clog2(MAX_BLOCKS);

    logic [AW-1:0] r_mem [MAX_BLOCKS];
    logic [AW-1:0] r_rd_data;

    // Free-index stack storage, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------
// i_req     in   func, free_offset
// o_rsp     out  status, block_offset, available, allocated
// APB       in   block_count at 0x0, block_bytes at 0x4
//
// One command at a time. Allocate does a stack read, then a multiply;
// free runs the divider, one quotient bit per cycle; clear and other
// codes go straight to the result state. A finished result waits in the
// output register while the next command is accepted. After reset the
// stack reads as identity indices; positions never written since the last
// clear are tracked by a high-water mark, so there is no clearing pass.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbpa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fbpa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbpa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    fbpa_req_if.sink                          i_req,
    fbpa_rsp_if.source                        o_rsp
);

    localparam int AW      = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = fbpa_pkg::CNT_W;
    localparam int OFF_W   = fbpa_pkg::OFF_W;
    localparam int BYTES_W = fbpa_pkg::BYTES_W;
    localparam int CAP_LIM = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    fbpa_pkg::t_func         r_func, n_func;
    fbpa_pkg::t_status       r_status, n_status;
    logic [OFF_W-1:0]        r_res_off, n_res_off;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_hw, n_hw;
    logic                    r_out_valid, n_out_valid;
    fbpa_pkg::t_status       r_o_status, n_o_status;
    logic [OFF_W-1:0]        r_o_off, n_o_off;
    logic [CNT_W-1:0]        r_o_avail, n_o_avail;
    logic [CNT_W-1:0]        r_o_alloc, n_o_alloc;

    logic [CNT_W-1:0]        w_block_count;
    logic [BYTES_W-1:0]      w_block_bytes;
    logic [CNT_W-1:0]        w_cap;
    logic [BYTES_W-1:0]      w_size;
    logic                    w_accept;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [OFF_W-1:0]        w_quot;
    logic [AW-1:0]           w_rd_data;
    logic [AW-1:0]           w_idx;
    logic [AW+BYTES_W-1:0]   w_prod;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic                    w_out_free;

    fbpa_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_block_count (w_block_count),
        .o_block_bytes (w_block_bytes)
    );

    // Capacity in use is the register capped at the stack depth and at 511; a zero size counts as one.
    assign w_cap  = (w_block_count > CNT_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : w_block_count;
    assign w_size = (w_block_bytes == '0) ? BYTES_W'(1) : w_block_bytes;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_div_start = w_accept && (i_req.func == fbpa_pkg::FUNC_FREE);

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.free_offset),
        .i_divisor  (w_size),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    fbpa_stack #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (AW'(r_count)),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (AW'(w_quot))
    );

    // A stack position at or above the high-water mark still holds its identity index.
    assign w_idx  = (r_count < r_hw) ? w_rd_data : AW'(r_count);
    assign w_prod = {{BYTES_W{1'b0}}, w_idx} * {{AW{1'b0}}, w_size};

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Push a freed index when the free commits.
    assign w_wr_en   = (r_state == S_DONE) && w_out_free &&
                       (r_func == fbpa_pkg::FUNC_FREE) && (r_status == fbpa_pkg::ST_OK);
    assign w_wr_addr = AW'(r_count - 1'b1);

    // Command sequencer and result register.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_status    = r_status;
        n_res_off   = r_res_off;
        n_count     = r_count;
        n_hw        = r_hw;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_off     = r_o_off;
        n_o_avail   = r_o_avail;
        n_o_alloc   = r_o_alloc;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func    = i_req.func;
                    n_status  = fbpa_pkg::ST_OK;
                    n_res_off = '0;
                    case (i_req.func)
                        fbpa_pkg::FUNC_ALLOC: begin
                            if (r_count >= w_cap) begin
                                n_status = fbpa_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        fbpa_pkg::FUNC_FREE: begin
                            if (r_count == '0) begin
                                n_status = fbpa_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                n_res_off = OFF_W'(w_prod);
                n_state   = S_DONE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_quot >= OFF_W'(w_cap)) begin
                        n_status = fbpa_pkg::ST_BADOFF;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    if (r_status == fbpa_pkg::ST_OK) begin
                        case (r_func)
                            fbpa_pkg::FUNC_ALLOC: begin
                                n_count = r_count + 1'b1;
                                if (r_count == r_hw) begin
                                    n_hw = r_count + 1'b1;
                                end
                            end
                            fbpa_pkg::FUNC_FREE:  n_count = r_count - 1'b1;
                            fbpa_pkg::FUNC_CLEAR: begin
                                n_count = '0;
                                n_hw    = '0;
                            end
                            default: ;
                        endcase
                    end
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_off     = r_res_off;
                    n_o_alloc   = n_count;
                    n_o_avail   = (n_count <= w_cap) ? (w_cap - n_count) : '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hw        <= n_hw;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_status   <= n_status;
        r_res_off  <= n_res_off;
        r_o_status <= n_o_status;
        r_o_off    <= n_o_off;
        r_o_avail  <= n_o_avail;
        r_o_alloc  <= n_o_alloc;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.block_offset = r_o_off;
    assign o_rsp.available    = r_o_avail;
    assign o_rsp.allocated    = r_o_alloc;

endmodule
